// ===== sv/kstep_pkg.sv =====
// Package: shared types and constants for the knob step accelerator with zero detent.
package kstep_pkg;

    localparam int KNOB_SLOTS = 6;
    localparam int SLOT_W = 3;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic MODE_OFFSET = 1'b0;
    localparam logic MODE_TRIGGER = 1'b1;
    localparam logic [1:0] OFFSET_SRC_LIMIT = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_TRIG_BASE = 3'd4;

    localparam logic [31:0] ACCEL_SLOW = 32'd75;
    localparam logic [31:0] ACCEL_MED = 32'd50;
    localparam logic [31:0] ACCEL_FAST = 32'd25;

    localparam logic [7:0] RST_STEP_SIZE = 8'd1;
    localparam logic signed [15:0] RST_OFFSET_ZERO = 16'sd500;
    localparam logic signed [15:0] RST_TRIGGER_ZERO = 16'sd500;
    localparam logic [15:0] RST_DWELL_MS = 16'd500;

    typedef enum logic [1:0] {
        REG_STEP_SIZE    = 2'd0,
        REG_OFFSET_ZERO  = 2'd1,
        REG_TRIGGER_ZERO = 2'd2,
        REG_DWELL_MS     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]         step_size;
        logic signed [15:0] offset_zero;
        logic signed [15:0] trigger_zero;
        logic [15:0]        dwell_ms;
    } kstep_cfg_t;

    typedef struct packed {
        logic               ignore;
        logic [1:0]         src;
        logic               dir;
        logic [SLOT_W-1:0]  slot;
        logic signed [15:0] zero;
        logic [31:0]        now;
        logic signed [15:0] cur;
    } kstep_item_t;

endpackage

// ===== sv/kstep_if.sv =====
// Interfaces: detent event channel and result channel.
interface kstep_evt_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [1:0]         src;
    logic               direction;
    logic [31:0]        now_ms;
    logic signed [15:0] current_value;

    modport source (output valid, mode, src, direction, now_ms, current_value,
                    input ready);
    modport sink (input valid, mode, src, direction, now_ms, current_value,
                  output ready);
endinterface

interface kstep_res_if;
    logic               valid;
    logic               ready;
    logic               apply;
    logic signed [15:0] new_value;
    logic               snapped;

    modport source (output valid, apply, new_value, snapped, input ready);
    modport sink (input valid, apply, new_value, snapped, output ready);
endinterface

// ===== sv/knob_step_accel_zero_detent.sv =====
// Top level: knob step accelerator with zero detent, APB register block and datapath.
// Takes one detent event per clock cycle while the queue is not full. A front end
// classifies each event (offset or trigger knob, slot, zero reference, ignored source)
// and pushes it into a two-entry queue; the back end pops one event per cycle while the
// result channel is not stalled and does the whole stateful update (time since the last
// detent, step multiplier 1 to 4, add, zero snap, dwell hold-off) as it pops, so the
// sustained rate is one transaction per cycle. Results pass the queue and the result
// register. Every event, including one for an unused source, gives exactly one result.
// Registers are written over APB at byte address 4*index; write them only while idle.
module knob_step_accel_zero_detent #(
    parameter int NUM_SOURCES = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    kstep_evt_if.sink                          evt,
    kstep_res_if.source                        res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kstep_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [kstep_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [kstep_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                               pready
);
    import kstep_pkg::*;

    kstep_cfg_t  cfg_reg;
    kstep_item_t push_item;
    kstep_item_t pop_item;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    cfg_reg_t    reg_sel;

    assign pready = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size <= RST_STEP_SIZE;
            cfg_reg.offset_zero <= RST_OFFSET_ZERO;
            cfg_reg.trigger_zero <= RST_TRIGGER_ZERO;
            cfg_reg.dwell_ms <= RST_DWELL_MS;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_STEP_SIZE:    cfg_reg.step_size <= pwdata[7:0];
                REG_OFFSET_ZERO:  cfg_reg.offset_zero <= pwdata[15:0];
                REG_TRIGGER_ZERO: cfg_reg.trigger_zero <= pwdata[15:0];
                REG_DWELL_MS:     cfg_reg.dwell_ms <= pwdata[15:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_STEP_SIZE:    prdata = {24'b0, cfg_reg.step_size};
            REG_OFFSET_ZERO:  prdata = {16'b0, cfg_reg.offset_zero};
            REG_TRIGGER_ZERO: prdata = {16'b0, cfg_reg.trigger_zero};
            REG_DWELL_MS:     prdata = {16'b0, cfg_reg.dwell_ms};
            default:          prdata = '0;
        endcase
    end

    kstep_front #(
        .NUM_SOURCES(NUM_SOURCES)
    ) u_front (
        .evt    (evt),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    kstep_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    kstep_back #(
        .NUM_SOURCES(NUM_SOURCES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

// ===== sv/kstep_front.sv =====
// Front end: accepts detent events, classifies target and knob slot.
module kstep_front #(
    parameter int NUM_SOURCES = 3
) (
    kstep_evt_if.sink           evt,
    input  kstep_pkg::kstep_cfg_t  cfg,
    input  logic                q_full,
    output logic                q_push,
    output kstep_pkg::kstep_item_t q_item
);
    import kstep_pkg::*;

    logic bad_src;

    always_comb
    begin
        if (evt.mode == MODE_TRIGGER)
        begin
            bad_src = (int'(evt.src) >= NUM_SOURCES);
        end
        else
        begin
            bad_src = (evt.src >= OFFSET_SRC_LIMIT);
        end
    end

    always_comb
    begin
        q_item.ignore = bad_src;
        q_item.src = evt.src;
        q_item.dir = evt.direction;
        if (evt.mode == MODE_TRIGGER)
        begin
            q_item.slot = SLOT_TRIG_BASE + {2'b00, evt.direction};
            q_item.zero = cfg.trigger_zero;
        end
        else
        begin
            q_item.slot = {evt.src[0], 1'b0, evt.direction} & 3'b011
                          | {1'b0, evt.src[0], 1'b0};
            q_item.zero = cfg.offset_zero;
        end
        q_item.now = evt.now_ms;
        q_item.cur = evt.current_value;
    end

    assign evt.ready = !q_full;
    assign q_push = evt.valid && !q_full;

endmodule

// ===== sv/kstep_queue.sv =====
// Two-entry queue between the front end and the back end.
module kstep_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  kstep_pkg::kstep_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output kstep_pkg::kstep_item_t pop_item
);
    import kstep_pkg::*;

    localparam int DEPTH = 2;

    kstep_item_t mem_reg [DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    assign full = (count_reg == 2'(DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== sv/kstep_back.sv =====
// Back end: acceleration, step, zero snap, dwell hold-off and result register.
module kstep_back #(
    parameter int NUM_SOURCES = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  kstep_pkg::kstep_cfg_t  cfg,
    input  logic                   q_valid,
    input  kstep_pkg::kstep_item_t q_item,
    output logic                   q_pop,
    kstep_res_if.source            res
);
    import kstep_pkg::*;

    logic [31:0]        last_reg [KNOB_SLOTS];
    logic [31:0]        dwell_start_reg [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] dwell_valid_reg;

    logic               res_valid_reg;
    logic               res_apply_reg;
    logic signed [15:0] res_value_reg;
    logic               res_snapped_reg;

    logic [31:0]        delta;
    logic [9:0]         step;
    logic [9:0]         step_x1;
    logic [9:0]         step_x2;
    logic signed [17:0] cur_x;
    logic signed [17:0] zero_x;
    logic signed [17:0] step_x;
    logic signed [17:0] sum;
    logic signed [17:0] final_sum;
    logic               snap;
    logic signed [15:0] wrapped;
    logic               dv;
    logic [31:0]        ds;
    logic               expired;
    logic               at_zero;
    logic               apply_c;
    logic               fire;

    assign delta = q_item.now - last_reg[q_item.slot];
    assign step_x1 = {2'b00, cfg.step_size};
    assign step_x2 = {1'b0, cfg.step_size, 1'b0};

    always_comb
    begin
        if (delta > ACCEL_SLOW)
        begin
            step = step_x1;
        end
        else if (delta > ACCEL_MED)
        begin
            step = step_x2;
        end
        else if (delta > ACCEL_FAST)
        begin
            step = step_x1 + step_x2;
        end
        else
        begin
            step = {cfg.step_size, 2'b00};
        end
    end

    assign cur_x = {{2{q_item.cur[15]}}, q_item.cur};
    assign zero_x = {{2{q_item.zero[15]}}, q_item.zero};
    assign step_x = {8'b0, step};
    assign sum = q_item.dir ? (cur_x + step_x) : (cur_x - step_x);
    assign snap = ((cur_x > zero_x) && (sum < zero_x)) || ((cur_x < zero_x) && (sum > zero_x));
    assign final_sum = snap ? zero_x : sum;
    assign wrapped = final_sum[15:0];

    always_comb
    begin
        dv = 1'b0;
        ds = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (int'(q_item.src) == i)
            begin
                dv = dwell_valid_reg[i];
                ds = dwell_start_reg[i];
            end
        end
    end

    assign expired = (q_item.now - ds) > {16'b0, cfg.dwell_ms};
    assign at_zero = (wrapped == q_item.zero);
    assign apply_c = at_zero || !dv || expired;

    assign fire = q_valid && (!res_valid_reg || res.ready);
    assign q_pop = fire;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (q_item.ignore)
            begin
                res_apply_reg <= 1'b0;
                res_value_reg <= q_item.cur;
                res_snapped_reg <= 1'b0;
            end
            else
            begin
                res_apply_reg <= apply_c;
                res_value_reg <= wrapped;
                res_snapped_reg <= snap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            dwell_valid_reg <= '0;
            for (int k = 0; k < KNOB_SLOTS; k++)
            begin
                last_reg[k] <= '0;
            end
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                dwell_start_reg[i] <= '0;
            end
        end
        else
        begin
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (fire && !q_item.ignore)
            begin
                last_reg[q_item.slot] <= q_item.now;
                for (int i = 0; i < NUM_SOURCES; i++)
                begin
                    if (int'(q_item.src) == i)
                    begin
                        if (at_zero)
                        begin
                            dwell_start_reg[i] <= q_item.now;
                            dwell_valid_reg[i] <= 1'b1;
                        end
                        else if (dv && expired)
                        begin
                            dwell_start_reg[i] <= '0;
                            dwell_valid_reg[i] <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    assign res.valid = res_valid_reg;
    assign res.apply = res_apply_reg;
    assign res.new_value = res_value_reg;
    assign res.snapped = res_snapped_reg;

endmodule

// ===== sv/kstep_checker.sv =====
// Checker: port-level assertions for the knob step accelerator, bound to the top level.
module kstep_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               evt_valid,
    input logic               evt_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic               res_apply,
    input logic signed [15:0] res_new_value,
    input logic               res_snapped
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_new_value)
            && $stable(res_apply) && $stable(res_snapped))
        else $error("stalled result changed");

    // landing on zero always restarts the dwell, so it is always applied
    a_snap_applies: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_snapped |-> res_apply)
        else $error("snapped result not applied");

    // an accepted transaction leads to a valid result on the result channel
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |-> ##2 res_valid)
        else $error("no result after accepted transaction");

endmodule

bind knob_step_accel_zero_detent kstep_checker u_kstep_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt_valid     (evt.valid),
    .evt_ready     (evt.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_apply     (res.apply),
    .res_new_value (res.new_value),
    .res_snapped   (res.snapped)
);
